// File: rtl/core/zbgsf_pkg.sv
package zbgsf_pkg;

  // item kinds carried in the func field
  localparam logic [1:0] FUNC_DRAW  = 2'd0;
  localparam logic [1:0] FUNC_CLEAR = 2'd1;
  localparam logic [1:0] FUNC_READ  = 2'd2;

  localparam logic [23:0] BG_RESET    = 24'hB4F0F0;
  localparam logic [31:0] CLEAR_DEPTH = 32'h8000_0001;  // -INT_MAX

  typedef struct packed {
    logic [1:0]         func;
    logic signed [15:0] x_start;
    logic signed [15:0] x_end;
    logic signed [15:0] row;
    logic signed [47:0] depth_start;
    logic signed [47:0] depth_step;
    logic signed [19:0] light_start;
    logic signed [19:0] light_step;
    logic [7:0]         base_red;
    logic [7:0]         base_green;
    logic [7:0]         base_blue;
  } in_t;

  typedef struct packed {
    logic [7:0] pixel_red;
    logic [7:0] pixel_green;
    logic [7:0] pixel_blue;
    logic [9:0] pixels_written;
  } out_t;

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_SETUP = 7'b0000010,
    ST_WALK  = 7'b0000100,
    ST_DRAIN = 7'b0001000,
    ST_CLEAR = 7'b0010000,
    ST_READ  = 7'b0100000,
    ST_DONE  = 7'b1000000
  } state_t;

endpackage

// File: rtl/core/zbuffer_gouraud_span_fill.sv
// Depth-buffered Gouraud span filler over an IMAGE_SIDE x IMAGE_SIDE image,
// with a 32-bit depth memory and a 24-bit color memory, one entry per pixel,
// both single-port-write / registered-read RAMs. One request is worked at a
// time; its result sits in an output register, so the next request is taken
// while that result waits. A draw request first scales the depth and light
// steps to the first visible column (bit-serial shift-add in ST_SETUP), then
// walks the clipped span at one pixel read-modify-write per cycle through a
// three-stage read/test/write pipe, then drains the pipe and posts; off-image
// or empty spans go straight to posting. A read request fetches one stored
// color and posts it. A clear request sweeps both memories one pixel per
// cycle. A finished request waits to post while the previous result is still
// held on the output.
// The memories hold garbage after reset; issue a clear before any draw or read.
module zbuffer_gouraud_span_fill #(
  parameter int IMAGE_SIDE = 512
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  zbgsf_pkg::in_t    in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output zbgsf_pkg::out_t   out_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [23:0]       cfg_data
);

  localparam int XW     = $clog2(IMAGE_SIDE);
  localparam int PIXELS = IMAGE_SIDE * IMAGE_SIDE;
  localparam int AW     = $clog2(PIXELS);
  localparam logic signed [16:0] X_MAX = 17'(IMAGE_SIDE - 1);

  zbgsf_pkg::state_t state_r, state_nxt;

  logic [31:0] depth_mem [PIXELS];
  logic [23:0] color_mem [PIXELS];
  logic [31:0] depth_q_r;
  logic [23:0] color_q_r;

  logic [23:0]        bg_rgb_r;
  logic               out_valid_r;
  zbgsf_pkg::out_t    out_data_r;

  // request context
  logic signed [63:0] d_r, dd_r, dsh_r;
  logic signed [39:0] l_r, ld_r, lsh_r;
  logic [15:0]        k0_r;
  logic [3:0]         sb_r;
  logic [XW-1:0]      x_r, hi_r;
  logic [AW-1:0]      base_r, clr_r;
  logic [7:0]         base_red_r, base_green_r, base_blue_r;
  logic [9:0]         count_r;
  logic [23:0]        rgb_r;

  // pipe stage B (read data back) and C (write)
  logic               p1_r, p2_r;
  logic [AW-1:0]      addr_b_r, addr_c_r;
  logic signed [63:0] d_b_r;
  logic [39:0]        mag_b_r;
  logic               pass_c_r, neg_c_r;
  logic [47:0]        rq_c_r;
  logic [47:0]        prod_r_r, prod_g_r, prod_b_r;

  // accept-side decode
  logic               in_acc, row_ok, xs_ok, span_ok;
  logic signed [16:0] lo_s, hi_s, xe_s;
  logic [AW-1:0]      in_row_base, in_addr;

  assign in_acc      = in_valid && in_ready;
  assign in_ready    = (state_r == zbgsf_pkg::ST_IDLE);
  assign cfg_ready   = 1'b1;
  assign out_valid   = out_valid_r;
  assign out_data    = out_data_r;

  assign row_ok      = !in_data.row[15] && (in_data.row[14:0] < 15'(IMAGE_SIDE));
  assign xs_ok       = !in_data.x_start[15] && (in_data.x_start[14:0] < 15'(IMAGE_SIDE));
  assign xe_s        = 17'(in_data.x_end);
  assign lo_s        = in_data.x_start[15] ? 17'sd0 : 17'(in_data.x_start);
  assign hi_s        = (xe_s > X_MAX) ? X_MAX : xe_s;
  assign span_ok     = row_ok && (lo_s <= hi_s);
  assign in_row_base = AW'(in_data.row[XW-1:0]) * AW'(IMAGE_SIDE);
  assign in_addr     = in_row_base + AW'(in_data.x_start[XW-1:0]);

  logic walk_issue, last_x, post;
  assign walk_issue = (state_r == zbgsf_pkg::ST_WALK);
  assign last_x     = (x_r == hi_r);
  assign post       = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      zbgsf_pkg::ST_IDLE: begin
        if (in_valid) begin
          unique case (in_data.func)
            zbgsf_pkg::FUNC_DRAW:  state_nxt = span_ok ? zbgsf_pkg::ST_SETUP
                                                       : zbgsf_pkg::ST_DONE;
            zbgsf_pkg::FUNC_CLEAR: state_nxt = zbgsf_pkg::ST_CLEAR;
            zbgsf_pkg::FUNC_READ:  state_nxt = (xs_ok && row_ok) ? zbgsf_pkg::ST_READ
                                                                 : zbgsf_pkg::ST_DONE;
            default:               state_nxt = zbgsf_pkg::ST_DONE;
          endcase
        end
      end
      zbgsf_pkg::ST_SETUP: if (sb_r == 4'd15) state_nxt = zbgsf_pkg::ST_WALK;
      zbgsf_pkg::ST_WALK:  if (last_x) state_nxt = zbgsf_pkg::ST_DRAIN;
      zbgsf_pkg::ST_DRAIN: if (!p1_r && !p2_r) state_nxt = zbgsf_pkg::ST_DONE;
      zbgsf_pkg::ST_CLEAR: if (clr_r == AW'(PIXELS - 1)) state_nxt = zbgsf_pkg::ST_DONE;
      zbgsf_pkg::ST_READ:  state_nxt = zbgsf_pkg::ST_DONE;
      zbgsf_pkg::ST_DONE:  if (post) state_nxt = zbgsf_pkg::ST_IDLE;
      default:             state_nxt = zbgsf_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= zbgsf_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
      p1_r        <= 1'b0;
      p2_r        <= 1'b0;
      bg_rgb_r    <= zbgsf_pkg::BG_RESET;
    end else begin
      state_r <= state_nxt;
      p1_r    <= walk_issue;
      p2_r    <= p1_r;
      if (cfg_valid) bg_rgb_r <= cfg_data;
      if (state_r == zbgsf_pkg::ST_DONE && post) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  // ---- stage B: stored depth is back; test, round, shade ----
  logic signed [63:0] stored_ext;
  logic [63:0]        rnd_sum;
  logic               neg_b;
  assign stored_ext = {{16{depth_q_r[31]}}, depth_q_r, 16'h0000};
  assign neg_b      = d_b_r[63];
  assign rnd_sum    = (neg_b ? ~d_b_r : d_b_r) + (neg_b ? 64'd32769 : 64'd32768);

  // ---- stage C: saturate and write ----
  function automatic logic [7:0] sat8(input logic [47:0] p);
    logic [32:0] c;
    c = 33'((49'(p) + 49'd32768) >> 16);
    return (c > 33'd255) ? 8'hFF : c[7:0];
  endfunction

  logic [31:0] depth_wr;
  logic [23:0] color_wr;
  always_comb begin
    if (!neg_c_r)
      depth_wr = (rq_c_r > 48'h7FFF_FFFF) ? 32'h7FFF_FFFF : rq_c_r[31:0];
    else
      depth_wr = (rq_c_r > 48'h8000_0000) ? 32'h8000_0000 : (~rq_c_r[31:0] + 32'd1);
    color_wr = {sat8(prod_r_r), sat8(prod_g_r), sat8(prod_b_r)};
  end

  logic          mem_we, pix_we, clr_we;
  logic [AW-1:0] mem_waddr;
  assign pix_we    = p2_r && pass_c_r;
  assign clr_we    = (state_r == zbgsf_pkg::ST_CLEAR);
  assign mem_we    = pix_we || clr_we;
  assign mem_waddr = clr_we ? clr_r : addr_c_r;

  // Span addresses only ascend, so a read never meets a pending write.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      depth_mem[mem_waddr] <= clr_we ? zbgsf_pkg::CLEAR_DEPTH : depth_wr;
      color_mem[mem_waddr] <= clr_we ? bg_rgb_r : color_wr;
    end
    if (walk_issue) depth_q_r <= depth_mem[base_r + AW'(x_r)];
    if (in_acc) color_q_r <= color_mem[in_addr];
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      d_r          <= 64'(in_data.depth_start);
      dd_r         <= 64'(in_data.depth_step);
      dsh_r        <= 64'(in_data.depth_step);
      l_r          <= 40'(in_data.light_start);
      ld_r         <= 40'(in_data.light_step);
      lsh_r        <= 40'(in_data.light_step);
      k0_r         <= in_data.x_start[15] ? (~in_data.x_start + 16'd1) : 16'd0;
      sb_r         <= 4'd0;
      x_r          <= lo_s[XW-1:0];
      hi_r         <= hi_s[XW-1:0];
      base_r       <= in_row_base;
      clr_r        <= '0;
      base_red_r   <= in_data.base_red;
      base_green_r <= in_data.base_green;
      base_blue_r  <= in_data.base_blue;
      count_r      <= 10'd0;
      rgb_r        <= 24'd0;
    end else begin
      case (state_r)
        zbgsf_pkg::ST_SETUP: begin
          // first column sits k0 steps past x_start
          if (k0_r[sb_r]) begin
            d_r <= d_r + dsh_r;
            l_r <= l_r + lsh_r;
          end
          dsh_r <= dsh_r <<< 1;
          lsh_r <= lsh_r <<< 1;
          sb_r  <= sb_r + 4'd1;
        end
        zbgsf_pkg::ST_WALK: begin
          d_r <= d_r + dd_r;
          l_r <= l_r + ld_r;
          x_r <= x_r + XW'(1);
        end
        zbgsf_pkg::ST_CLEAR: clr_r <= clr_r + AW'(1);
        zbgsf_pkg::ST_READ:  rgb_r <= color_q_r;
        default: ;
      endcase
      if (pix_we) count_r <= count_r + 10'd1;
    end

    // stage A -> B
    addr_b_r <= base_r + AW'(x_r);
    d_b_r    <= d_r;
    mag_b_r  <= l_r[39] ? (~l_r + 40'd1) : l_r;

    // stage B -> C
    addr_c_r <= addr_b_r;
    pass_c_r <= stored_ext < d_b_r;
    neg_c_r  <= neg_b;
    rq_c_r   <= rnd_sum[63:16];
    prod_r_r <= 48'(base_red_r) * 48'(mag_b_r);
    prod_g_r <= 48'(base_green_r) * 48'(mag_b_r);
    prod_b_r <= 48'(base_blue_r) * 48'(mag_b_r);

    if (state_r == zbgsf_pkg::ST_DONE && post) begin
      out_data_r.pixel_red      <= rgb_r[23:16];
      out_data_r.pixel_green    <= rgb_r[15:8];
      out_data_r.pixel_blue     <= rgb_r[7:0];
      out_data_r.pixels_written <= count_r;
    end
  end

endmodule

// File: rtl/core/zbgsf_chk.sv
module zbgsf_chk (
  input logic            clk,
  input logic            rst_n,
  input logic            in_valid,
  input logic            in_ready,
  input logic            out_valid,
  input logic            out_ready,
  input zbgsf_pkg::out_t out_data
);

  // a result waiting on the far side stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result dropped or changed while stalled");

  // one request in flight: taking a request closes the input
  a_one_inflight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second request taken while one is in flight");

  // only a read carries a color, only a draw carries a count
  a_kind_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.pixels_written == 10'd0) ||
                  ({out_data.pixel_red, out_data.pixel_green, out_data.pixel_blue} == 24'd0))
    else $error("result carries both a color and a count");

  // every request yields a result: input reopens only after a result is posted
  a_result_before_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready ##1 in_ready |-> $rose(out_valid) || $past(out_valid) && out_valid ||
                               $rose(out_valid))
    else $error("input reopened without a posted result");

endmodule

bind zbuffer_gouraud_span_fill zbgsf_chk u_zbgsf_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

// File: tb/sv/tb_zbuffer_gouraud_span_fill.sv
`timescale 1ns / 100ps

module tb_zbuffer_gouraud_span_fill;

  localparam int IMG = 512;
  localparam int PIXELS = IMG * IMG;
  localparam logic [1:0] FUNC_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 6_000_000;
  localparam int DRAIN_CYCLES = 600;
  localparam longint ONE_Q16 = 65536;
  localparam longint DEPTH48_MAX = 64'sd140737488355327;
  localparam longint DEPTH48_MIN = -64'sd140737488355328;
  localparam longint DEPTH_MAX = 64'sd2147483647;
  localparam longint DEPTH_MIN = -64'sd2147483648;

  logic            clk;
  logic            rst_n;
  logic            in_valid;
  logic            in_ready;
  zbgsf_pkg::in_t  in_data;
  logic            out_valid;
  logic            out_ready;
  zbgsf_pkg::out_t out_data;
  logic            cfg_valid;
  logic            cfg_ready;
  logic [23:0]     cfg_data;

  // shadow frame: depth and color per pixel, plus the background register
  int          frame_depth [PIXELS];
  logic [23:0] frame_color [PIXELS];
  logic [23:0] shadow_bg_rgb;

  zbgsf_pkg::out_t expected_pixels [$];
  int   errors = 0;
  int   cycle_count = 0;
  int   rx_hold_cycles = 0;
  bit   tx_gaps_on = 1'b1;
  bit   rx_gaps_on = 1'b1;

  zbuffer_gouraud_span_fill #(.IMAGE_SIDE(IMG)) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: run exceeded %0d cycles", $time, CYCLE_LIMIT);
      $display("zbuffer_gouraud_span_fill test failed");
      $finish;
    end
  end

  function automatic logic [7:0] scale_channel(input logic [7:0] base, input longint mag);
    longint c;
    c = (longint'(base) * mag + 32768) >>> 16;
    return (c > 255) ? 8'd255 : c[7:0];
  endfunction

  // Updates the shadow frame and returns the result the block must post.
  function automatic zbgsf_pkg::out_t render_request(input zbgsf_pkg::in_t req);
    zbgsf_pkg::out_t res;
    longint          xs, xe, rw, lo, hi, x, k, d, l, q, mag;
    int              idx;
    int              i;
    logic [9:0]      written;
    logic [23:0]     rgb;
    res = '0;
    written = '0;
    rgb = '0;
    xs = longint'(req.x_start);
    xe = longint'(req.x_end);
    rw = longint'(req.row);
    case (req.func)
      zbgsf_pkg::FUNC_DRAW: begin
        lo = (xs < 0) ? 0 : xs;
        hi = (xe > IMG - 1) ? IMG - 1 : xe;
        if (rw >= 0 && rw < IMG) begin
          for (x = lo; x <= hi; x++) begin
            k = x - xs;
            d = longint'(req.depth_start) + k * longint'(req.depth_step);
            l = longint'(req.light_start) + k * longint'(req.light_step);
            idx = int'(rw) * IMG + int'(x);
            if (longint'(frame_depth[idx]) * ONE_Q16 < d) begin
              mag = (l < 0) ? -l : l;
              // round halves away from zero, then clamp to 32 bits
              q = (d >= 0) ? ((d + 32768) >>> 16) : -((-d + 32768) >>> 16);
              if (q > DEPTH_MAX) q = DEPTH_MAX;
              if (q < DEPTH_MIN) q = DEPTH_MIN;
              frame_depth[idx] = int'(q);
              frame_color[idx] = {scale_channel(req.base_red, mag),
                                  scale_channel(req.base_green, mag),
                                  scale_channel(req.base_blue, mag)};
              written = written + 10'd1;
            end
          end
        end
      end
      zbgsf_pkg::FUNC_CLEAR: begin
        for (i = 0; i < PIXELS; i++) begin
          frame_depth[i] = int'(zbgsf_pkg::CLEAR_DEPTH);
          frame_color[i] = shadow_bg_rgb;
        end
      end
      zbgsf_pkg::FUNC_READ: begin
        if (xs >= 0 && xs < IMG && rw >= 0 && rw < IMG)
          rgb = frame_color[int'(rw) * IMG + int'(xs)];
      end
      default: ;
    endcase
    res.pixel_red = rgb[23:16];
    res.pixel_green = rgb[15:8];
    res.pixel_blue = rgb[7:0];
    res.pixels_written = written;
    return res;
  endfunction

  function automatic void compare_field(input string fname, input logic [9:0] want,
                                        input logic [9:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, fname, want, got);
      errors++;
    end
  endfunction

  always @(posedge clk) begin : result_check
    zbgsf_pkg::out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_pixels.size() == 0) begin
        $display("%0t: result with no request pending, expected none, actual %h",
                 $time, out_data);
        errors++;
      end else begin
        want = expected_pixels.pop_front();
        compare_field("pixel_red", 10'(want.pixel_red), 10'(out_data.pixel_red));
        compare_field("pixel_green", 10'(want.pixel_green), 10'(out_data.pixel_green));
        compare_field("pixel_blue", 10'(want.pixel_blue), 10'(out_data.pixel_blue));
        compare_field("pixels_written", want.pixels_written, out_data.pixels_written);
      end
    end
  end

  function automatic int pick_gap(input bit enabled);
    int r;
    if (!enabled) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 4);
    return $urandom_range(8, 60);
  endfunction

  // result side: random stalls, plus a long hold-off when a test asks for one
  initial begin : result_sink
    int gap;
    out_ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (rx_hold_cycles > 0) begin
        out_ready <= 1'b0;
        repeat (rx_hold_cycles) @(posedge clk);
        rx_hold_cycles = 0;
      end else begin
        gap = ($urandom_range(0, 3) == 0) ? pick_gap(rx_gaps_on) : 0;
        if (gap > 0) begin
          out_ready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
        out_ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // valid stays up into the next request when no gap follows
  task automatic send_request(input zbgsf_pkg::in_t req);
    int gap;
    in_valid <= 1'b1;
    in_data <= req;
    do @(posedge clk); while (!in_ready);
    expected_pixels.insert(expected_pixels.size(), render_request(req));
    gap = pick_gap(tx_gaps_on);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_results_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_pixels.size() != 0);
  endtask

  task automatic write_background(input logic [23:0] rgb);
    cfg_valid <= 1'b1;
    cfg_data <= rgb;
    do @(posedge clk); while (!cfg_ready);
    shadow_bg_rgb = rgb;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic zbgsf_pkg::in_t simple_request(input logic [1:0] f);
    zbgsf_pkg::in_t req;
    req = '0;
    req.func = f;
    return req;
  endfunction

  function automatic zbgsf_pkg::in_t read_req(input int rw, input int x);
    zbgsf_pkg::in_t req;
    req = '0;
    req.func = zbgsf_pkg::FUNC_READ;
    req.row = 16'(rw);
    req.x_start = 16'(x);
    return req;
  endfunction

  function automatic zbgsf_pkg::in_t draw_req(input int rw, xs, xe, input longint ds, dd,
                                              input int ls, ld, input logic [7:0] r, g, b);
    zbgsf_pkg::in_t req;
    req.func = zbgsf_pkg::FUNC_DRAW;
    req.row = 16'(rw);
    req.x_start = 16'(xs);
    req.x_end = 16'(xe);
    req.depth_start = 48'(ds);
    req.depth_step = 48'(dd);
    req.light_start = 20'(ls);
    req.light_step = 20'(ld);
    req.base_red = r;
    req.base_green = g;
    req.base_blue = b;
    return req;
  endfunction

  // Mostly short spans and reads on a few busy rows so that depth tests
  // collide; the rest keeps raw noise in every field but the func code.
  function automatic zbgsf_pkg::in_t random_request();
    zbgsf_pkg::in_t req;
    logic [223:0]   noise;
    int             pick, rw, xs, len;
    noise = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    req = noise[$bits(zbgsf_pkg::in_t)-1:0];
    pick = $urandom_range(0, 99);
    if (pick < 60) begin
      rw = (pick < 52) ? $urandom_range(0, 15) : $urandom_range(0, IMG - 1);
      if ($urandom_range(0, 19) == 0) begin
        xs = 0;
        len = IMG;
      end else begin
        xs = int'($urandom_range(0, IMG + 15)) - 16;
        len = $urandom_range(0, 23);
      end
      req.func = zbgsf_pkg::FUNC_DRAW;
      req.row = 16'(rw);
      req.x_start = 16'(xs);
      req.x_end = 16'(xs + len - 1);
      req.depth_start = 48'(longint'(int'($urandom_range(0, 2000)) - 1000) * ONE_Q16
                            + longint'($urandom_range(0, 65535)));
      req.depth_step = 48'(longint'(int'($urandom_range(0, 1 << 19)) - (1 << 18)));
      req.light_start = 20'(int'($urandom_range(0, 1 << 18)) - (1 << 17));
      req.light_step = 20'(int'($urandom_range(0, 4000)) - 2000);
    end else if (pick < 85) begin
      req.func = zbgsf_pkg::FUNC_READ;
      req.row = 16'((pick < 80) ? $urandom_range(0, 15) : $urandom_range(0, IMG - 1));
      req.x_start = 16'($urandom_range(0, IMG - 1));
    end else if (pick < 95) begin
      req.func = zbgsf_pkg::FUNC_DRAW;
    end else if (pick < 98) begin
      req.func = FUNC_UNUSED;
    end else begin
      req.func = zbgsf_pkg::FUNC_READ;
    end
    return req;
  endfunction

  task automatic test_reset_clear_and_reads();
    zbgsf_pkg::in_t req;
    // first clear uses the background the block comes out of reset with
    send_request(simple_request(zbgsf_pkg::FUNC_CLEAR));
    send_request(read_req(0, 0));
    send_request(read_req(IMG - 1, IMG - 1));
    send_request(read_req(-1, 0));
    send_request(read_req(0, IMG));
    send_request(read_req(32767, -32768));
    req = '1;
    req.func = FUNC_UNUSED;
    send_request(req);
    wait_results_drained();
  endtask

  task automatic test_directed_spans();
    // full row; same depth again must lose, one LSB nearer must win
    send_request(draw_req(0, 0, IMG - 1, 10 * ONE_Q16, 0, 1 << 16, 0, 8'd255, 8'd128, 8'd0));
    send_request(draw_req(0, 0, IMG - 1, 10 * ONE_Q16, 0, 1 << 16, 0, 8'd1, 8'd2, 8'd3));
    send_request(draw_req(0, 5, 5, 10 * ONE_Q16 + 1, 0, 1 << 16, 0, 8'd9, 8'd9, 8'd9));
    send_request(read_req(0, 5));
    // widest span, clipped to the row with a large column offset
    send_request(draw_req(1, -32768, 32767, 0, 1, -524288, 0, 8'd255, 8'd1, 8'd0));
    send_request(read_req(1, IMG - 1));
    send_request(draw_req(2, 3, 2, 0, 0, 1 << 16, 0, 8'd7, 8'd7, 8'd7));
    send_request(draw_req(-1, 0, 10, 0, 0, 1 << 16, 0, 8'd7, 8'd7, 8'd7));
    send_request(draw_req(IMG, 0, 10, 0, 0, 1 << 16, 0, 8'd7, 8'd7, 8'd7));
    // depth at both ends of the 48-bit range
    send_request(draw_req(3, 0, 3, DEPTH48_MAX, 0, 1 << 16, 0, 8'd40, 8'd50, 8'd60));
    send_request(draw_req(4, 0, 3, DEPTH48_MIN, 0, 1 << 16, 0, 8'd40, 8'd50, 8'd60));
    send_request(read_req(3, 3));
    // halves round away from zero for depth and color
    send_request(draw_req(5, 0, 1, 5 * ONE_Q16 + 32768, -11 * ONE_Q16, 1 << 15, 0,
                          8'd1, 8'd3, 8'd255));
    send_request(read_req(5, 0));
    send_request(read_req(5, 1));
    // intensity at its extremes, including values past the field range
    send_request(draw_req(6, 0, 2, 0, 0, 524287, -524288, 8'd0, 8'd255, 8'd17));
    send_request(read_req(6, 1));
    send_request(read_req(6, 2));
    wait_results_drained();
  endtask

  task automatic test_random_traffic(input int count, input bit tx_idle, input bit rx_idle);
    tx_gaps_on = tx_idle;
    rx_gaps_on = rx_idle;
    repeat (count) send_request(random_request());
    wait_results_drained();
  endtask

  // result side stops for a long time while requests keep coming
  task automatic test_output_backpressure();
    tx_gaps_on = 1'b0;
    rx_hold_cycles = 3000;
    repeat (24) send_request(random_request());
    wait_results_drained();
  endtask

  task automatic test_sender_pause();
    tx_gaps_on = 1'b1;
    rx_gaps_on = 1'b1;
    repeat (15) send_request(random_request());
    wait_results_drained();
    repeat (15) send_request(random_request());
    wait_results_drained();
  endtask

  // block is idle on entry: every test ends with all results back
  task automatic test_background_clear(input logic [23:0] rgb);
    write_background(rgb);
    send_request(simple_request(zbgsf_pkg::FUNC_CLEAR));
    send_request(read_req(0, 0));
    send_request(read_req(IMG - 1, IMG - 1));
    send_request(read_req($urandom_range(0, IMG - 1), $urandom_range(0, IMG - 1)));
    wait_results_drained();
  endtask

  // a register write alone must leave the stored frame untouched
  task automatic test_background_write_only();
    write_background(24'($urandom));
    send_request(read_req(0, 0));
    send_request(read_req($urandom_range(0, 15), $urandom_range(0, IMG - 1)));
    send_request(read_req($urandom_range(0, IMG - 1), $urandom_range(0, IMG - 1)));
    wait_results_drained();
  endtask

  initial begin : run_tests
    in_valid <= 1'b0;
    in_data <= '0;
    cfg_valid <= 1'b0;
    cfg_data <= '0;
    rst_n <= 1'b0;
    shadow_bg_rgb = zbgsf_pkg::BG_RESET;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_clear_and_reads();
    test_directed_spans();
    test_random_traffic(350, 1'b1, 1'b1);
    test_output_backpressure();
    test_background_clear(24'h000000);
    test_random_traffic(300, 1'b0, 1'b0);
    test_sender_pause();
    test_background_clear(24'hFFFFFF);
    test_random_traffic(400, 1'b1, 1'b1);
    test_background_write_only();

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && expected_pixels.size() == 0) begin
      $display("zbuffer_gouraud_span_fill test passed");
    end else begin
      $display("zbuffer_gouraud_span_fill test failed");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/core/zbgsf_pkg.sv
rtl/core/zbuffer_gouraud_span_fill.sv
rtl/core/zbgsf_chk.sv
tb/sv/tb_zbuffer_gouraud_span_fill.sv
